### rtl/core/tcw_pkg.sv
// Shared types and constants of the text console writer.
package tcw_pkg;

   localparam int CODE_W = 9;
   localparam int ADDR_W = 11;
   localparam int POS_W = 11;
   localparam int DATA_W = 16;
   localparam int COLOR_W = 4;
   localparam int CSR_IDX_W = 1;

   localparam logic [CODE_W-1:0] CODE_BACKSPACE = 9'h100;
   localparam logic [CODE_W-1:0] CODE_NEWLINE = 9'd10;

   localparam logic REQ_PUT = 1'b0;
   localparam logic REQ_READ = 1'b1;

   localparam logic [CSR_IDX_W-1:0] CSR_FG_COLOR = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_BG_COLOR = 1'b1;

   localparam logic [COLOR_W-1:0] FG_COLOR_RESET = 4'hF;
   localparam logic [COLOR_W-1:0] BG_COLOR_RESET = 4'h0;

   typedef struct packed {
      logic req_type;
      logic [CODE_W-1:0] char_code;
      logic [ADDR_W-1:0] read_address;
   } tcw_req_type;

   typedef struct packed {
      logic [POS_W-1:0] cursor_position;
      logic [DATA_W-1:0] read_data;
      logic scrolled;
   } tcw_rsp_type;

   typedef enum logic [2:0] {
      ST_INIT,
      ST_IDLE,
      ST_EXEC,
      ST_SCROLL,
      ST_DRAIN,
      ST_CLEAR
   } tcw_state_type;

endpackage

### rtl/core/tcw_ram.sv
// Generic single-write, single-read RAM with a registered read port.
module tcw_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 2000
) (
   input  logic clock,
   input  logic wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/core/text_console_writer.sv
// Top level of the text console writer: cell store, cursor and control sequencer.
//
// The console keeps ROWS*COLUMNS character cells in one RAM and a cursor. After
// reset, busy stays high while the RAM is cleared one cell per cycle. A read or a
// put that does not scroll ends in EXEC with a registered result; a put that scrolls
// moves each row but the first up one row (SCROLL, DRAIN), then clears the last row
// (CLEAR) through the single RAM write port, one cell per cycle. Each item gives one
// result, shown for one cycle with rsp_valid high; the receiver cannot stall it.
// The user must write colors via the csr port only while idle; nothing enforces it.
module text_console_writer #(
   parameter int COLUMNS = 80,
   parameter int ROWS = 25
) (
   input  logic clock,
   input  logic reset,
   input  logic start,
   output logic busy,
   input  tcw_pkg::tcw_req_type req_item,
   output logic rsp_valid,
   output tcw_pkg::tcw_rsp_type rsp_item,
   input  logic csr_we,
   input  logic [tcw_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [tcw_pkg::COLOR_W-1:0] csr_wdata
);

   localparam int CELLS = COLUMNS * ROWS;
   localparam int AW = $clog2(CELLS);
   localparam int CW = $clog2(CELLS + 1);
   localparam int COLW = $clog2(COLUMNS);
   localparam int PosW = tcw_pkg::POS_W;
   localparam int DataW = tcw_pkg::DATA_W;

   tcw_pkg::tcw_state_type state_ff, state_in;
   tcw_pkg::tcw_req_type req_ff;
   tcw_pkg::tcw_rsp_type rsp_ff, rsp_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic [AW-1:0] cursor_ff, cursor_in;
   logic [COLW-1:0] col_ff, col_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic pend_ff, pend_in;
   logic [AW-1:0] pend_addr_ff, pend_addr_in;
   logic [tcw_pkg::COLOR_W-1:0] fg_ff, bg_ff;

   logic accept;
   logic ram_we;
   logic [AW-1:0] ram_waddr;
   logic [DataW-1:0] ram_wdata;
   logic [AW-1:0] ram_raddr;
   logic [DataW-1:0] ram_rdata;

   logic [CW-1:0] cur_ext;
   logic [CW-1:0] nxt_pos;
   logic [CW-1:0] fix_pos;
   logic [COLW-1:0] nxt_col;
   logic put_wr;
   logic scroll_hit;
   logic in_range;
   logic cnt_last;

   assign accept = start && !busy;
   assign busy = (state_ff != tcw_pkg::ST_IDLE);
   assign cnt_last = (cnt_ff == CW'(CELLS - 1));
   assign in_range = (32'(req_ff.read_address) < CELLS);

   tcw_ram #(
      .WIDTH(DataW),
      .DEPTH(CELLS)
   ) u_cells (
      .clock(clock),
      .wr_en(ram_we),
      .wr_addr(ram_waddr),
      .wr_data(ram_wdata),
      .rd_addr(ram_raddr),
      .rd_data(ram_rdata)
   );

   always_comb begin
      cur_ext = CW'(cursor_ff);
      nxt_pos = cur_ext;
      nxt_col = col_ff;
      put_wr = 1'b0;
      case (req_ff.char_code)
         tcw_pkg::CODE_BACKSPACE: begin
            if (cursor_ff != '0) begin
               nxt_pos = cur_ext - CW'(1);
               nxt_col = (col_ff == '0) ? COLW'(COLUMNS - 1) : col_ff - COLW'(1);
            end
         end
         tcw_pkg::CODE_NEWLINE: begin
            nxt_pos = cur_ext - CW'(col_ff) + CW'(COLUMNS);
            nxt_col = '0;
         end
         default: begin
            put_wr = 1'b1;
            nxt_pos = cur_ext + CW'(1);
            nxt_col = (col_ff == COLW'(COLUMNS - 1)) ? '0 : col_ff + COLW'(1);
         end
      endcase
      scroll_hit = (nxt_pos >= CW'(CELLS));
      fix_pos = scroll_hit ? nxt_pos - CW'(COLUMNS) : nxt_pos;
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         tcw_pkg::ST_INIT: begin
            if (cnt_last) begin
               state_in = tcw_pkg::ST_IDLE;
            end
         end
         tcw_pkg::ST_IDLE: begin
            if (accept) begin
               state_in = tcw_pkg::ST_EXEC;
            end
         end
         tcw_pkg::ST_EXEC: begin
            if (req_ff.req_type == tcw_pkg::REQ_PUT && scroll_hit) begin
               state_in = tcw_pkg::ST_SCROLL;
            end else begin
               state_in = tcw_pkg::ST_IDLE;
            end
         end
         tcw_pkg::ST_SCROLL: begin
            if (cnt_last) begin
               state_in = tcw_pkg::ST_DRAIN;
            end
         end
         tcw_pkg::ST_DRAIN: begin
            state_in = tcw_pkg::ST_CLEAR;
         end
         tcw_pkg::ST_CLEAR: begin
            if (cnt_last) begin
               state_in = tcw_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = tcw_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      ram_we = 1'b0;
      ram_waddr = cnt_ff[AW-1:0];
      ram_wdata = '0;
      ram_raddr = AW'(req_item.read_address);
      cnt_in = cnt_ff;
      pend_in = 1'b0;
      pend_addr_in = pend_addr_ff;
      cursor_in = cursor_ff;
      col_in = col_ff;
      rsp_valid_in = 1'b0;
      rsp_in = rsp_ff;
      unique case (state_ff)
         tcw_pkg::ST_INIT: begin
            ram_we = 1'b1;
            cnt_in = cnt_ff + CW'(1);
         end
         tcw_pkg::ST_IDLE: begin
         end
         tcw_pkg::ST_EXEC: begin
            if (req_ff.req_type == tcw_pkg::REQ_READ) begin
               rsp_valid_in = 1'b1;
               rsp_in.cursor_position = PosW'(cursor_ff);
               rsp_in.read_data = in_range ? ram_rdata : '0;
               rsp_in.scrolled = 1'b0;
            end else begin
               if (put_wr) begin
                  ram_we = 1'b1;
                  ram_waddr = cursor_ff;
                  ram_wdata = {bg_ff, fg_ff, req_ff.char_code[7:0]};
               end
               cursor_in = fix_pos[AW-1:0];
               col_in = nxt_col;
               if (scroll_hit) begin
                  cnt_in = CW'(COLUMNS);
               end else begin
                  rsp_valid_in = 1'b1;
                  rsp_in.cursor_position = PosW'(fix_pos);
                  rsp_in.read_data = '0;
                  rsp_in.scrolled = 1'b0;
               end
            end
         end
         tcw_pkg::ST_SCROLL: begin
            ram_raddr = cnt_ff[AW-1:0];
            pend_in = 1'b1;
            pend_addr_in = AW'(cnt_ff - CW'(COLUMNS));
            cnt_in = cnt_ff + CW'(1);
         end
         tcw_pkg::ST_DRAIN: begin
            cnt_in = CW'(CELLS - COLUMNS);
         end
         tcw_pkg::ST_CLEAR: begin
            ram_we = 1'b1;
            cnt_in = cnt_ff + CW'(1);
            if (cnt_last) begin
               rsp_valid_in = 1'b1;
               rsp_in.cursor_position = PosW'(cursor_ff);
               rsp_in.read_data = '0;
               rsp_in.scrolled = 1'b1;
            end
         end
         default: begin
         end
      endcase
      if (pend_ff) begin
         ram_we = 1'b1;
         ram_waddr = pend_addr_ff;
         ram_wdata = ram_rdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= tcw_pkg::ST_INIT;
         cnt_ff <= '0;
         cursor_ff <= '0;
         col_ff <= '0;
         pend_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         fg_ff <= tcw_pkg::FG_COLOR_RESET;
         bg_ff <= tcw_pkg::BG_COLOR_RESET;
      end else begin
         state_ff <= state_in;
         cnt_ff <= cnt_in;
         cursor_ff <= cursor_in;
         col_ff <= col_in;
         pend_ff <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            unique case (csr_index)
               tcw_pkg::CSR_FG_COLOR: fg_ff <= csr_wdata;
               tcw_pkg::CSR_BG_COLOR: bg_ff <= csr_wdata;
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      pend_addr_ff <= pend_addr_in;
      rsp_ff <= rsp_in;
      if (accept) begin
         req_ff <= req_item;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item = rsp_ff;

   a_cursor_bound: assert property (@(posedge clock) disable iff (reset)
      (32'(cursor_ff) < CELLS) && (32'(col_ff) < COLUMNS))
      else $error("cursor outside the screen");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      accept |=> busy)
      else $error("block not busy after an accepted item");

   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (state_ff == tcw_pkg::ST_IDLE))
      else $error("result shown while the sequencer is still working");

   a_pend_scroll: assert property (@(posedge clock) disable iff (reset)
      pend_ff |-> (state_ff == tcw_pkg::ST_SCROLL || state_ff == tcw_pkg::ST_DRAIN))
      else $error("row move write outside a scroll");

endmodule

### tb/tb_text_console_writer.sv
// Self-checking testbench for the text console writer: puts, reads, scrolling and colors.
module tb_text_console_writer;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int COLUMNS = 80;
   localparam int ROWS = 25;
   localparam int CELLS = COLUMNS * ROWS;
   localparam int CYCLE_LIMIT = 4_000_000;
   localparam int PRINT_LIMIT = 50;
   localparam int CODE_W = tcw_pkg::CODE_W;
   localparam int ADDR_W = tcw_pkg::ADDR_W;
   localparam int POS_W = tcw_pkg::POS_W;
   localparam int DATA_W = tcw_pkg::DATA_W;
   localparam int COLOR_W = tcw_pkg::COLOR_W;
   localparam int CSR_IDX_W = tcw_pkg::CSR_IDX_W;

   logic clock;
   logic reset;
   logic start;
   logic busy;
   tcw_pkg::tcw_req_type req_item;
   logic rsp_valid;
   tcw_pkg::tcw_rsp_type rsp_item;
   logic csr_we;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [COLOR_W-1:0] csr_wdata;

   logic [DATA_W-1:0] shadow_cells [CELLS];
   int shadow_cursor;
   logic [COLOR_W-1:0] shadow_fg;
   logic [COLOR_W-1:0] shadow_bg;

   tcw_pkg::tcw_rsp_type pending_rsp [$];
   tcw_pkg::tcw_rsp_type expected_rsp;

   int error_count = 0;
   int item_count = 0;
   int read_count = 0;
   int scroll_count = 0;
   int color_count = 0;
   int cycle_count = 0;

   text_console_writer #(
      .COLUMNS(COLUMNS),
      .ROWS(ROWS)
   ) DUT (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_item(req_item),
      .rsp_valid(rsp_valid),
      .rsp_item(rsp_item),
      .csr_we(csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   initial clock = 1'b0;
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles with %0d items outstanding.", cycle_count,
                  pending_rsp.size());
         $display("simulation failed");
         $finish;
      end
   end

   function automatic tcw_pkg::tcw_rsp_type console_apply(input tcw_pkg::tcw_req_type req);
      tcw_pkg::tcw_rsp_type rsp;
      int c;
      logic [7:0] attr;
      rsp = '0;
      attr = {shadow_bg, shadow_fg};
      if (req.req_type == tcw_pkg::REQ_READ) begin
         if (req.read_address < CELLS) begin
            rsp.read_data = shadow_cells[req.read_address];
         end
      end else begin
         if (req.char_code == tcw_pkg::CODE_BACKSPACE) begin
            if (shadow_cursor > 0) begin
               shadow_cursor = shadow_cursor - 1;
            end
         end else if (req.char_code == tcw_pkg::CODE_NEWLINE) begin
            shadow_cursor = shadow_cursor + COLUMNS - shadow_cursor % COLUMNS;
         end else begin
            if (shadow_cursor < CELLS) begin
               shadow_cells[shadow_cursor] = {attr, req.char_code[7:0]};
            end
            shadow_cursor = shadow_cursor + 1;
         end
         if (shadow_cursor >= CELLS) begin
            for (c = 0; c < CELLS - COLUMNS; c++) begin
               shadow_cells[c] = shadow_cells[c + COLUMNS];
            end
            for (c = CELLS - COLUMNS; c < CELLS; c++) begin
               shadow_cells[c] = '0;
            end
            shadow_cursor = shadow_cursor - COLUMNS;
            rsp.scrolled = 1'b1;
         end
      end
      rsp.cursor_position = shadow_cursor[POS_W-1:0];
      return rsp;
   endfunction

   task automatic report_mismatch(input string msg);
      if (error_count < PRINT_LIMIT) begin
         $display("MISMATCH at cycle %0d: %s", cycle_count, msg);
      end
      error_count++;
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (pending_rsp.size() == 0) begin
            report_mismatch($sformatf("result %p with no item outstanding", rsp_item));
         end else begin
            expected_rsp = pending_rsp.pop_front();
            if (rsp_item.cursor_position !== expected_rsp.cursor_position) begin
               report_mismatch($sformatf("cursor_position got %0d expected %0d",
                  rsp_item.cursor_position, expected_rsp.cursor_position));
            end
            if (rsp_item.read_data !== expected_rsp.read_data) begin
               report_mismatch($sformatf("read_data got %h expected %h",
                  rsp_item.read_data, expected_rsp.read_data));
            end
            if (rsp_item.scrolled !== expected_rsp.scrolled) begin
               report_mismatch($sformatf("scrolled got %b expected %b",
                  rsp_item.scrolled, expected_rsp.scrolled));
            end
         end
      end
   end

   function automatic tcw_pkg::tcw_req_type make_put(input logic [CODE_W-1:0] code);
      tcw_pkg::tcw_req_type req;
      req.req_type = tcw_pkg::REQ_PUT;
      req.char_code = code;
      req.read_address = ADDR_W'($urandom);
      return req;
   endfunction

   function automatic tcw_pkg::tcw_req_type make_read(input logic [ADDR_W-1:0] addr);
      tcw_pkg::tcw_req_type req;
      req.req_type = tcw_pkg::REQ_READ;
      req.char_code = CODE_W'($urandom);
      req.read_address = addr;
      return req;
   endfunction

   function automatic tcw_pkg::tcw_req_type random_item();
      int kind;
      kind = $urandom_range(0, 99);
      if (kind < 30) begin
         if ($urandom_range(0, 9) == 0) begin
            return make_read(ADDR_W'($urandom_range(0, 2047)));
         end
         return make_read(ADDR_W'($urandom_range(0, CELLS - 1)));
      end
      kind = $urandom_range(0, 99);
      if (kind < 5) begin
         return make_put(tcw_pkg::CODE_NEWLINE);
      end else if (kind < 12) begin
         return make_put(tcw_pkg::CODE_BACKSPACE);
      end else if (kind < 22) begin
         return make_put(CODE_W'($urandom_range(0, 511)));
      end
      return make_put(CODE_W'($urandom_range(32, 126)));
   endfunction

   task automatic send_item(input tcw_pkg::tcw_req_type req);
      tcw_pkg::tcw_rsp_type exp;
      @(negedge clock);
      req_item <= req;
      start <= 1'b1;
      do @(posedge clock); while (busy);
      exp = console_apply(req);
      pending_rsp.push_back(exp);
      item_count++;
      if (req.req_type == tcw_pkg::REQ_READ) read_count++;
      if (exp.scrolled) scroll_count++;
   endtask

   task automatic idle_burst(input int cycles);
      repeat (cycles) begin
         @(negedge clock);
         start <= 1'b0;
      end
   endtask

   task automatic wait_idle();
      @(negedge clock);
      start <= 1'b0;
      while (pending_rsp.size() != 0 || busy) @(negedge clock);
   endtask

   task automatic write_color(input logic [CSR_IDX_W-1:0] index,
                              input logic [COLOR_W-1:0] value);
      wait_idle();
      csr_we <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      if (index == tcw_pkg::CSR_FG_COLOR) shadow_fg = value;
      else shadow_bg = value;
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic set_colors(input logic [COLOR_W-1:0] fg, input logic [COLOR_W-1:0] bg);
      write_color(tcw_pkg::CSR_FG_COLOR, fg);
      write_color(tcw_pkg::CSR_BG_COLOR, bg);
      color_count++;
   endtask

   task automatic test_directed();
      send_item(make_read(ADDR_W'(0)));
      send_item(make_read(ADDR_W'(CELLS - 1)));
      send_item(make_read(ADDR_W'(CELLS)));
      send_item(make_read(11'h7FF));
      send_item(make_put(tcw_pkg::CODE_BACKSPACE));
      send_item(make_put(CODE_W'("A")));
      send_item(make_put(9'h000));
      send_item(make_put(9'h0FF));
      send_item(make_put(9'h1FF));
      send_item(make_put(9'h10A));
      send_item(make_put(tcw_pkg::CODE_BACKSPACE));
      send_item(make_put(CODE_W'("B")));
      send_item(make_put(tcw_pkg::CODE_NEWLINE));
      send_item(make_put(tcw_pkg::CODE_NEWLINE));
      send_item(make_put(tcw_pkg::CODE_BACKSPACE));
      send_item(make_put(CODE_W'("Z")));
      send_item(make_read(ADDR_W'(0)));
      send_item(make_read(ADDR_W'(1)));
      send_item(make_read(ADDR_W'(3)));
      send_item(make_read(ADDR_W'(4)));
      send_item(make_read(ADDR_W'(2 * COLUMNS - 1)));
   endtask

   task automatic test_scroll();
      int i;
      set_colors(4'hA, 4'h5);
      while (shadow_cursor < CELLS - COLUMNS) begin
         send_item(make_put(tcw_pkg::CODE_NEWLINE));
      end
      send_item(make_put(tcw_pkg::CODE_NEWLINE));
      for (i = 0; i < COLUMNS; i++) begin
         send_item(make_put(CODE_W'($urandom_range(32, 126))));
         if ($urandom_range(0, 5) == 0) idle_burst($urandom_range(1, 4));
      end
      send_item(make_read(ADDR_W'(CELLS - COLUMNS)));
      send_item(make_read(ADDR_W'(CELLS - 1)));
      send_item(make_read(ADDR_W'(CELLS - COLUMNS - 1)));
      send_item(make_read(ADDR_W'(CELLS - 2 * COLUMNS)));
      send_item(make_put(tcw_pkg::CODE_BACKSPACE));
   endtask

   task automatic test_random_text(input logic [COLOR_W-1:0] fg,
                                   input logic [COLOR_W-1:0] bg,
                                   input int count, input bit quiet_tail);
      int i;
      set_colors(fg, bg);
      for (i = 0; i < count; i++) begin
         send_item(random_item());
         if ((!quiet_tail || i < count / 2) && $urandom_range(0, 3) == 0) begin
            idle_burst($urandom_range(1, 4));
         end
      end
   endtask

   initial begin
      reset = 1'b1;
      start = 1'b0;
      req_item = '0;
      csr_we = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      foreach (shadow_cells[i]) shadow_cells[i] = '0;
      shadow_cursor = 0;
      shadow_fg = tcw_pkg::FG_COLOR_RESET;
      shadow_bg = tcw_pkg::BG_COLOR_RESET;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_directed();
      test_scroll();
      test_random_text(4'h0, 4'h0, 75, 1'b0);
      test_random_text(4'hF, 4'hF, 75, 1'b0);
      test_random_text(COLOR_W'($urandom_range(0, 15)), COLOR_W'($urandom_range(0, 15)),
                       75, 1'b0);
      test_random_text(tcw_pkg::FG_COLOR_RESET, tcw_pkg::BG_COLOR_RESET, 75, 1'b1);

      wait_idle();
      repeat (20) @(posedge clock);
      $display("Run covered %0d items: %0d reads, %0d scrolls, %0d color settings.",
               item_count, read_count, scroll_count, color_count);
      $display("Mismatches found: %0d in %0d cycles.", error_count, cycle_count);
      if (error_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

### sim.f
rtl/core/tcw_pkg.sv
rtl/core/tcw_ram.sv
rtl/core/text_console_writer.sv
tb/tb_text_console_writer.sv
